>>> hw/rtl/copf_pkg.sv
// ----------------------------------------------------------------------------
// copf_pkg
// Shared widths, register indexes and decision codes for the core online policy.
// ----------------------------------------------------------------------------
package copf_pkg;

	localparam int FREQ_W  = 22;
	localparam int LIMIT_W = 3;
	localparam int DELAY_W = 16;
	localparam int MASK_W  = 4;
	localparam int FIELDS  = 4;

	localparam int IN_W  = 88;   // four frequencies, already whole bytes
	localparam int OUT_W = 48;   // 44 bits of fields, padded to six bytes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 22;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOP_FREQ    = 2'd0,
		REG_CORE_LIMIT  = 2'd1,
		REG_SHORT_DELAY = 2'd2,
		REG_LONG_DELAY  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		DEC_NONE    = 2'd0,
		DEC_ALL_UP  = 2'd1,
		DEC_ONE_UP  = 2'd2,
		DEC_ONE_DN  = 2'd3
	} decision_t;

	localparam logic [FREQ_W-1:0]  TOP_FREQ_RST    = 22'd1190400;
	localparam logic [LIMIT_W-1:0] CORE_LIMIT_RST  = 3'd4;
	localparam logic [DELAY_W-1:0] SHORT_DELAY_RST = 16'd600;
	localparam logic [DELAY_W-1:0] LONG_DELAY_RST  = 16'd1000;

endpackage

>>> hw/rtl/core_online_policy_by_frequency.sv
// ----------------------------------------------------------------------------
// core_online_policy_by_frequency
// Per-tick core hotplug decision from the peak frequency of the online cores.
// ----------------------------------------------------------------------------
// Each input beat passes the input register, then the result register.
// Throughput: one tick per cycle unless m_tready is low; the online mask, previous peak
// and delay flag update as the tick leaves the input register, so the next tick sees them.
// Reset: all cores online, previous peak zero, short delay, registers at defaults.
module core_online_policy_by_frequency #(
	parameter int NUM_CORES = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// freq_core0, freq_core1, freq_core2, freq_core3 (22 bits each)
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [copf_pkg::IN_W-1:0]         s_tdata,
	// online_cores[3:0], decision[5:4], next_delay_ms[21:6], peak_frequency[43:22]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [copf_pkg::OUT_W-1:0]        m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [copf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [copf_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int FW = copf_pkg::FREQ_W;

	// configuration
	logic [FW-1:0]                     top_freq_q;
	logic [copf_pkg::LIMIT_W-1:0]      core_limit_q;
	logic [copf_pkg::DELAY_W-1:0]      short_delay_q;
	logic [copf_pkg::DELAY_W-1:0]      long_delay_q;

	// policy state
	logic [NUM_CORES-1:0]              mask_q;
	logic [FW-1:0]                     prev_peak_q;
	logic                              last_long_q;

	// pipeline
	logic                              valid_s1;
	logic [copf_pkg::IN_W-1:0]         data_s1;
	logic                              out_valid_q;
	logic [copf_pkg::OUT_W-1:0]        out_data_q;
	logic                              advance;

	// tick evaluation
	logic [FW-1:0]                     freq_in [copf_pkg::FIELDS];
	logic [FW-1:0]                     peak;
	logic [copf_pkg::LIMIT_W-1:0]      lim_eff;
	logic [NUM_CORES-1:0]              allow;
	logic [NUM_CORES-1:0]              mask_base;
	logic [NUM_CORES-1:0]              mask_next;
	copf_pkg::decision_t               decision;
	logic                              go_long;
	logic                              up_found;
	logic                              dn_found;
	logic [copf_pkg::MASK_W-1:0]       online4;
	logic [copf_pkg::DELAY_W-1:0]      delay;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_freq_q    <= copf_pkg::TOP_FREQ_RST;
			core_limit_q  <= copf_pkg::CORE_LIMIT_RST;
			short_delay_q <= copf_pkg::SHORT_DELAY_RST;
			long_delay_q  <= copf_pkg::LONG_DELAY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				copf_pkg::REG_TOP_FREQ:    top_freq_q    <= cfg_data;
				copf_pkg::REG_CORE_LIMIT:  core_limit_q  <= cfg_data[copf_pkg::LIMIT_W-1:0];
				copf_pkg::REG_SHORT_DELAY: short_delay_q <= cfg_data[copf_pkg::DELAY_W-1:0];
				copf_pkg::REG_LONG_DELAY:  long_delay_q  <= cfg_data[copf_pkg::DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int j = 0; j < copf_pkg::FIELDS; j++)
			freq_in[j] = data_s1[j*FW +: FW];
	end

	always_comb begin
		lim_eff = (core_limit_q == '0) ? copf_pkg::LIMIT_W'(1) : core_limit_q;
		for (int i = 0; i < NUM_CORES; i++)
			allow[i] = (copf_pkg::LIMIT_W'(i) < lim_eff);
	end

	// peak over online cores; cores beyond the four fields read as zero
	always_comb begin
		peak = '0;
		for (int i = 0; i < NUM_CORES; i++) begin
			if (i < copf_pkg::FIELDS) begin
				if (mask_q[i] && freq_in[2'(i)] > peak)
					peak = freq_in[2'(i)];
			end
		end
	end

	always_comb begin
		decision  = copf_pkg::DEC_NONE;
		go_long   = 1'b0;
		mask_base = mask_q;
		if (peak == top_freq_q) begin
			mask_base = mask_q | allow;
			decision  = copf_pkg::DEC_ALL_UP;
		end else if (peak > prev_peak_q) begin
			decision = copf_pkg::DEC_ONE_UP;
		end else if (peak == prev_peak_q) begin
			if (last_long_q)
				decision = copf_pkg::DEC_ONE_DN;
			else
				go_long = 1'b1;
		end else begin
			decision = copf_pkg::DEC_ONE_DN;
			go_long  = last_long_q;
		end
	end

	// lowest core from index one up, moved only when allowed; core 0 never changes here
	always_comb begin
		mask_next = mask_base;
		up_found  = 1'b0;
		dn_found  = 1'b0;
		for (int i = 1; i < NUM_CORES; i++) begin
			if (decision == copf_pkg::DEC_ONE_UP && !up_found && !mask_base[i]) begin
				up_found = 1'b1;
				if (allow[i])
					mask_next[i] = 1'b1;
			end
			if (decision == copf_pkg::DEC_ONE_DN && !dn_found && mask_base[i]) begin
				dn_found = 1'b1;
				if (allow[i])
					mask_next[i] = 1'b0;
			end
		end
	end

	always_comb begin
		online4 = '0;
		for (int j = 0; j < NUM_CORES; j++) begin
			if (j < copf_pkg::MASK_W)
				online4[2'(j)] = mask_next[j];
		end
		delay = go_long ? long_delay_q : short_delay_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			mask_q      <= '1;
			prev_peak_q <= '0;
			last_long_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				out_valid_q <= valid_s1;
			if (valid_s1 && advance) begin
				mask_q      <= mask_next;
				prev_peak_q <= peak;
				last_long_q <= go_long;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			data_s1 <= s_tdata;
		if (valid_s1 && advance)
			out_data_q <= {4'b0000, peak, delay, decision, online4};
	end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams frequency ticks into the core online policy across several register
// settings and handshake pressure patterns; a scoreboard predicts each result.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic [copf_pkg::MASK_W-1:0]  cores;
		copf_pkg::decision_t          dec;
		logic [copf_pkg::DELAY_W-1:0] delay;
		logic [copf_pkg::FREQ_W-1:0]  peak;
	} policy_out_t;

	class tick_scoreboard;
		logic [copf_pkg::FREQ_W-1:0]  top_freq;
		logic [copf_pkg::LIMIT_W-1:0] core_lim;
		logic [copf_pkg::DELAY_W-1:0] short_dly;
		logic [copf_pkg::DELAY_W-1:0] long_dly;
		logic [copf_pkg::MASK_W-1:0]  online;
		logic [copf_pkg::FREQ_W-1:0]  prev_peak;
		bit                           was_long;
		policy_out_t                  expected_q[$];
		int                           errors;

		function new();
			top_freq  = copf_pkg::TOP_FREQ_RST;
			core_lim  = copf_pkg::CORE_LIMIT_RST;
			short_dly = copf_pkg::SHORT_DELAY_RST;
			long_dly  = copf_pkg::LONG_DELAY_RST;
			online    = '1;
			prev_peak = '0;
			was_long  = 0;
			errors    = 0;
		endfunction

		function void set_reg(copf_pkg::reg_idx_t idx, logic [copf_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				copf_pkg::REG_TOP_FREQ:    top_freq  = val[copf_pkg::FREQ_W-1:0];
				copf_pkg::REG_CORE_LIMIT:  core_lim  = val[copf_pkg::LIMIT_W-1:0];
				copf_pkg::REG_SHORT_DELAY: short_dly = val[copf_pkg::DELAY_W-1:0];
				copf_pkg::REG_LONG_DELAY:  long_dly  = val[copf_pkg::DELAY_W-1:0];
				default: ;
			endcase
		endfunction

		// lowest core at index one or above whose online bit equals want; 4 if none
		function int first_core(logic [copf_pkg::MASK_W-1:0] m, bit want);
			for (int i = 1; i < copf_pkg::MASK_W; i++)
				if (m[i] == want)
					return i;
			return copf_pkg::MASK_W;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_tick(logic [copf_pkg::IN_W-1:0] d);
			logic [copf_pkg::MASK_W-1:0] m;
			logic [copf_pkg::FREQ_W-1:0] f;
			policy_out_t                 r;
			int                          lim;
			int                          c;
			bit                          go_long;
			m       = online;
			lim     = (core_lim == 0) ? 1 : int'(core_lim);
			r.peak  = '0;
			r.dec   = copf_pkg::DEC_NONE;
			go_long = 0;
			for (int i = 0; i < copf_pkg::FIELDS; i++) begin
				f = d[i*copf_pkg::FREQ_W +: copf_pkg::FREQ_W];
				if (m[i] && f > r.peak)
					r.peak = f;
			end
			if (r.peak == top_freq) begin
				for (int i = 0; i < copf_pkg::MASK_W; i++)
					if (i < lim)
						m[i] = 1'b1;
				r.dec = copf_pkg::DEC_ALL_UP;
			end else if (r.peak > prev_peak) begin
				r.dec = copf_pkg::DEC_ONE_UP;
			end else if (r.peak == prev_peak) begin
				if (was_long)
					r.dec = copf_pkg::DEC_ONE_DN;
				else
					go_long = 1;
			end else begin
				r.dec   = copf_pkg::DEC_ONE_DN;
				go_long = was_long;
			end
			// the decision stands even when no core can move
			if (r.dec == copf_pkg::DEC_ONE_UP) begin
				c = first_core(m, 1'b0);
				if (c < copf_pkg::MASK_W && c < lim)
					m[c] = 1'b1;
			end else if (r.dec == copf_pkg::DEC_ONE_DN) begin
				c = first_core(m, 1'b1);
				if (c < copf_pkg::MASK_W && c < lim)
					m[c] = 1'b0;
			end
			online    = m;
			prev_peak = r.peak;
			was_long  = go_long;
			r.cores   = m;
			r.delay   = go_long ? long_dly : short_dly;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [copf_pkg::OUT_W-1:0] d);
			policy_out_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result beat %h", d));
				return;
			end
			e = expected_q.pop_front();
			if (d[3:0] !== e.cores)
				report($sformatf("online_cores %h, expected %h", d[3:0], e.cores));
			if (d[5:4] !== e.dec)
				report($sformatf("decision %0d, expected %s", d[5:4], e.dec.name()));
			if (d[21:6] !== e.delay)
				report($sformatf("next_delay_ms %0d, expected %0d", d[21:6], e.delay));
			if (d[43:22] !== e.peak)
				report($sformatf("peak_frequency %0d, expected %0d", d[43:22], e.peak));
		endtask
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [copf_pkg::IN_W-1:0]       s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [copf_pkg::OUT_W-1:0]      m_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [copf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [copf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	tick_scoreboard sb = new();
	int idle_pct  = 0;
	int stall_pct = 0;
	logic [copf_pkg::IN_W-1:0] last_tick = '0;

	core_online_policy_by_frequency i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	function automatic logic [copf_pkg::IN_W-1:0] ticks(logic [copf_pkg::FREQ_W-1:0] f0,
			logic [copf_pkg::FREQ_W-1:0] f1, logic [copf_pkg::FREQ_W-1:0] f2,
			logic [copf_pkg::FREQ_W-1:0] f3);
		return {f3, f2, f1, f0};
	endfunction

	task automatic send_tick(logic [copf_pkg::IN_W-1:0] d);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_tick(d);
		last_tick = d;
	endtask

	task automatic end_burst();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic write_reg(copf_pkg::reg_idx_t idx, logic [copf_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// random levels mixed with zero, all ones, the top and four shared levels so that peaks repeat, hit the top and fall
	function automatic logic [copf_pkg::FREQ_W-1:0] pick_freq();
		case ($urandom_range(9))
			0, 1, 2, 3: return copf_pkg::FREQ_W'($urandom);
			4: return '0;
			5: return '1;
			6: return sb.top_freq;
			default: begin
				case ($urandom_range(3))
					0: return 22'd300000;
					1: return 22'd600000;
					2: return 22'd900000;
					default: return 22'd1190400;
				endcase
			end
		endcase
	endfunction

	function automatic logic [copf_pkg::IN_W-1:0] random_tick();
		logic [copf_pkg::IN_W-1:0] d;
		d = last_tick;
		case ($urandom_range(9))
			0, 1: ;                                            // same load again
			2: d[copf_pkg::FREQ_W-1:0] = pick_freq();          // only core 0 moves
			default: d = ticks(pick_freq(), pick_freq(), pick_freq(), pick_freq());
		endcase
		return d;
	endfunction

	logic [copf_pkg::CFG_DATA_W-1:0] ph_top[8]   = '{22'd1190400, 22'd0, 22'h3FFFFF,
		22'd500000, 22'd900000, 22'd1190400, 22'd300000, 22'd600000};
	logic [copf_pkg::CFG_DATA_W-1:0] ph_lim[8]   = '{22'd4, 22'd1, 22'd2, 22'd3, 22'd0, 22'd7,
		22'd13, 22'd4};
	logic [copf_pkg::CFG_DATA_W-1:0] ph_short[8] = '{22'd600, 22'd0, 22'd65535, 22'd123, 22'd7,
		22'd600, 22'd1, 22'd4321};
	logic [copf_pkg::CFG_DATA_W-1:0] ph_long[8]  = '{22'd1000, 22'd65535, 22'd0, 22'd456, 22'd9,
		22'd1000, 22'd2, 22'd8765};
	int ph_idle[4]  = '{0, 52, 0, 38};
	int ph_stall[4] = '{0, 0, 52, 38};

	logic [copf_pkg::IN_W-1:0] directed[18];

	initial begin
		directed = '{
			ticks(0, 0, 0, 0),                   // equal peak on short delay: hold, go long
			ticks(0, 0, 0, 0),                   // equal on long: drop core 1
			ticks(0, 22'h3FFFFF, 0, 0),          // offline core ignored
			ticks(1000, 0, 0, 0),                // rise: core 1 back
			ticks(0, 0, 0, 22'h3FFFFF),          // rise with nothing offline
			ticks(500, 0, 0, 0),                 // fall on short
			ticks(0, 0, 22'd1190400, 0),         // top frequency: all up
			ticks(22'd1190400, 22'h3FFFFF, 0, 0),
			ticks(22'd1190400, 22'h3FFFFF, 0, 0),
			ticks(100, 0, 0, 0),                 // fall on long keeps long
			ticks(100, 0, 0, 0),
			ticks(100, 0, 0, 0),
			ticks(50, 0, 0, 0),
			ticks(50, 0, 0, 0),                  // only core 0 left, nothing moves
			ticks(22'h2AAAAA, 22'h155555, 22'h2AAAAA, 22'h155555),
			ticks(22'h155555, 22'h2AAAAA, 22'h155555, 22'h2AAAAA),
			ticks(22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF),
			ticks(22'd1190400, 22'd1190400, 22'd1190400, 22'd1190400)
		};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, pattern walk with a busy receiver
		stall_pct = 38;
		foreach (directed[i])
			send_tick(directed[i]);
		end_burst();

		for (int p = 0; p < 8; p++) begin
			wait_drained();
			if (p == 7) begin
				ph_top[p]   = ($urandom_range(1) != 0) ? 22'd1190400 :
					copf_pkg::CFG_DATA_W'($urandom);
				ph_lim[p]   = copf_pkg::CFG_DATA_W'($urandom_range(7));
				ph_short[p] = copf_pkg::CFG_DATA_W'($urandom_range(65535));
				ph_long[p]  = copf_pkg::CFG_DATA_W'($urandom_range(65535));
			end
			write_reg(copf_pkg::REG_TOP_FREQ, ph_top[p]);
			write_reg(copf_pkg::REG_CORE_LIMIT, ph_lim[p]);
			write_reg(copf_pkg::REG_SHORT_DELAY, ph_short[p]);
			write_reg(copf_pkg::REG_LONG_DELAY, ph_long[p]);
			idle_pct  = ph_idle[p % 4];
			stall_pct = ph_stall[p % 4];
			repeat (150)
				send_tick(random_tick());
			end_burst();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
